// ===== rtl/knmd_pkg.sv =====
// ----------------------------------------------------------------------------
// knmd_pkg
// Shared widths and types of the keyword nearest Manhattan distance block.
// ----------------------------------------------------------------------------
package knmd_pkg;

   localparam int MAX_POINTS = 64;
   localparam int KEYWORDS   = 16;
   localparam int COORD_W    = 16;

   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int KW_IDX_W   = 4;
   localparam int CNT_W      = 7;
   localparam int DIST_W     = COORD_W + 1;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // One stored point, as held in the point memory
   typedef struct packed {
      logic [KEYWORDS-1:0] kw_mask;
      logic [COORD_W-1:0]  y;
      logic [COORD_W-1:0]  x;
   } point_type;

   // Sequencer controls towards the distance unit
   typedef struct packed {
      logic                clear;
      logic                load_q;
      logic [KW_IDX_W-1:0] kw_index;
   } dist_ctl_type;

   // Distance unit status back to the sequencer
   typedef struct packed {
      logic              busy;
      logic              found;
      logic [DIST_W-1:0] best;
   } dist_sts_type;

endpackage

// ===== rtl/knmd_point_mem.sv =====
// ----------------------------------------------------------------------------
// knmd_point_mem
// Point table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module knmd_point_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [knmd_pkg::ADDR_W-1:0] wr_addr,
   input  knmd_pkg::point_type        wr_data,
   input  logic [knmd_pkg::ADDR_W-1:0] rd_addr,
   output knmd_pkg::point_type        rd_data
);

   knmd_pkg::point_type mem [knmd_pkg::MAX_POINTS];
   knmd_pkg::point_type rd_data_ff;

   // Write one slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one slot every cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/knmd_dist_unit.sv =====
// ----------------------------------------------------------------------------
// knmd_dist_unit
// Two-stage distance datapath: Manhattan distance of each scanned point,
// then a running minimum over the points that hold the keyword.
// ----------------------------------------------------------------------------
module knmd_dist_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  knmd_pkg::dist_ctl_type ctl,
   input  logic                   rd_vld,
   input  knmd_pkg::point_type    rd_data,
   output knmd_pkg::dist_sts_type sts
);

   logic [knmd_pkg::COORD_W-1:0]  qx_ff, qx_in;
   logic [knmd_pkg::COORD_W-1:0]  qy_ff, qy_in;
   logic [knmd_pkg::KW_IDX_W-1:0] kw_ff, kw_in;
   logic [knmd_pkg::DIST_W-1:0]   d_ff, d_in;
   logic                          hit_ff, hit_in;
   logic                          dvld_ff, dvld_in;
   logic [knmd_pkg::DIST_W-1:0]   best_ff, best_in;
   logic                          found_ff, found_in;
   logic [knmd_pkg::COORD_W-1:0]  ax, ay;
   logic                          kw_ok;

   // Hold the query point and keyword
   always_comb begin
      qx_in = ctl.load_q ? rd_data.x : qx_ff;
      qy_in = ctl.load_q ? rd_data.y : qy_ff;
      kw_in = ctl.clear ? ctl.kw_index : kw_ff;
   end

   // Stage one: distance and keyword hit of the point just read
   always_comb begin
      ax      = (qx_ff >= rd_data.x) ? (qx_ff - rd_data.x) : (rd_data.x - qx_ff);
      ay      = (qy_ff >= rd_data.y) ? (qy_ff - rd_data.y) : (rd_data.y - qy_ff);
      kw_ok   = (32'(kw_ff) < knmd_pkg::KEYWORDS);
      d_in    = knmd_pkg::DIST_W'(ax) + knmd_pkg::DIST_W'(ay);
      hit_in  = kw_ok && rd_data.kw_mask[kw_ff];
      dvld_in = rd_vld && !ctl.clear;
   end

   // Stage two: keep the smallest distance seen
   always_comb begin
      best_in  = best_ff;
      found_in = found_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (dvld_ff && hit_ff && (!found_ff || (d_ff < best_ff))) begin
         best_in  = d_ff;
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         dvld_ff  <= dvld_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      kw_ff   <= kw_in;
      d_ff    <= d_in;
      hit_ff  <= hit_in;
      best_ff <= best_in;
   end

   assign sts.busy  = dvld_ff;
   assign sts.found = found_ff;
   assign sts.best  = best_ff;

endmodule

// ===== rtl/keyword_nearest_manhattan_distance.sv =====
// ----------------------------------------------------------------------------
// keyword_nearest_manhattan_distance
// Keyword nearest neighbour search under the Manhattan metric.
//
// A load beat (req_tuser = 0) writes x, y and keyword mask into one slot of
// the point table and gives no result. A query beat (req_tuser = 1) names a
// stored point and a keyword and returns one rsp beat: the smallest
// |dx|+|dy| from that point to any point among the first point_count slots
// that holds the keyword, 0 when the queried point holds it itself, and
// rsp_tuser = 1 with distance 0 when none does. When the queried point holds
// the keyword or point_count is zero, no scan is run. Otherwise the scan reads
// the point memory once per slot through its single read port, one slot per
// cycle, up to MAX_POINTS = 64. req_tready stays low while a query runs. A
// stalled receiver holds the output register; a further query is still taken
// and scanned, then holds in its last step with req_tready low until the
// waiting result is taken. Reset clears control state and sets point_count
// to 1; the table is undefined until loaded. csr writes must be made only
// while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module keyword_nearest_manhattan_distance (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: slot_index[5:0], x_coord[21:6], y_coord[37:22],
   //        keyword_mask[53:38], keyword_index[57:54], zero[63:58]
   input  logic [63:0] req_tdata,
   // tuser: command
   input  logic        req_tuser,
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: distance[16:0], zero[23:17]
   output logic [23:0] rsp_tdata,
   // tuser: none_found
   output logic        rsp_tuser,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_OWN  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam int AW = knmd_pkg::ADDR_W;
   localparam int CW = knmd_pkg::CNT_W;
   localparam int DW = knmd_pkg::DIST_W;

   logic [1:0]                    state_ff, state_in;
   logic [CW-1:0]                 point_count_ff, point_count_in;
   logic [CW-1:0]                 limit_ff, limit_in;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic [knmd_pkg::KW_IDX_W-1:0] kw_ff, kw_in;
   logic                          own_ff, own_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic                          rsp_vld_ff, rsp_vld_in;
   logic [DW-1:0]                 rsp_dist_ff, rsp_dist_in;
   logic                          rsp_none_ff, rsp_none_in;

   logic                          req_acc;
   logic                          is_query;
   logic [AW-1:0]                 req_slot;
   logic [knmd_pkg::KW_IDX_W-1:0] req_kw;
   logic                          mem_we;
   knmd_pkg::point_type           wr_point;
   logic [AW-1:0]                 rd_addr;
   knmd_pkg::point_type           rd_point;
   logic                          scan_issue;
   logic                          out_free;
   logic                          own_hit;
   knmd_pkg::dist_ctl_type        ctl;
   knmd_pkg::dist_sts_type        sts;

   // Unpack the request beat
   assign req_slot = req_tdata[5:0];
   assign req_kw   = req_tdata[57:54];
   assign wr_point.x       = req_tdata[21:6];
   assign wr_point.y       = req_tdata[37:22];
   assign wr_point.kw_mask = req_tdata[53:38];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign is_query   = (req_tuser == knmd_pkg::CMD_QUERY);
   assign mem_we     = req_acc && (req_tuser == knmd_pkg::CMD_LOAD)
                       && (32'(req_slot) < knmd_pkg::MAX_POINTS);

   // Issue the next scan read while slots remain
   assign scan_issue = (state_ff == ST_SCAN) && (idx_ff < limit_ff);
   assign rd_addr    = (state_ff == ST_IDLE) ? req_slot : idx_ff[AW-1:0];
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign own_hit    = (32'(kw_ff) < knmd_pkg::KEYWORDS) && rd_point.kw_mask[kw_ff];

   assign ctl.clear    = req_acc && is_query;
   assign ctl.load_q   = (state_ff == ST_OWN);
   assign ctl.kw_index = req_kw;

   knmd_point_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (req_slot),
      .wr_data (wr_point),
      .rd_addr (rd_addr),
      .rd_data (rd_point)
   );

   knmd_dist_unit u_dist (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_vld  (rd_vld_ff),
      .rd_data (rd_point),
      .sts     (sts)
   );

   // Sequencer: own point check, slot scan, hand over to the output register
   always_comb begin
      state_in       = state_ff;
      point_count_in = csr_wr_en ? csr_wr_data : point_count_ff;
      limit_in       = limit_ff;
      idx_in         = idx_ff;
      kw_in          = kw_ff;
      own_in         = own_ff;
      rd_vld_in      = scan_issue;
      rsp_vld_in     = rsp_vld_ff && !rsp_tready;
      rsp_dist_in    = rsp_dist_ff;
      rsp_none_in    = rsp_none_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && is_query) begin
               kw_in    = req_kw;
               limit_in = (32'(point_count_ff) > knmd_pkg::MAX_POINTS)
                          ? CW'(knmd_pkg::MAX_POINTS) : point_count_ff;
               state_in = ST_OWN;
            end
         end
         ST_OWN: begin
            own_in = own_hit;
            idx_in = '0;
            if (own_hit || (limit_ff == '0)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_issue) begin
               idx_in = idx_ff + 1'b1;
            end else if (!rd_vld_ff && !sts.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_none_in = !(own_ff || sts.found);
               rsp_dist_in = (!own_ff && sts.found) ? sts.best : '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= CW'(1);
         rd_vld_ff      <= 1'b0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         point_count_ff <= point_count_in;
         rd_vld_ff      <= rd_vld_in;
         rsp_vld_ff     <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff    <= limit_in;
      idx_ff      <= idx_in;
      kw_ff       <= kw_in;
      own_ff      <= own_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_none_ff <= rsp_none_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(24 - DW)'(0), rsp_dist_ff};
   assign rsp_tuser  = rsp_none_ff;

   // The scan pipeline has drained before a result is handed over
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!rd_vld_ff && !sts.busy))
      else $error("result taken while scan reads in flight");

   // Scan reads happen only while scanning
   a_rd_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN))
      else $error("scan read outside scan state");

   // The own point check follows a query acceptance
   a_own_after_query: assert property (@(posedge clock) disable iff (reset)
      (req_acc && is_query) |=> (state_ff == ST_OWN))
      else $error("query not followed by own point check");

   // A none result carries distance zero
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_none_ff) |-> (rsp_dist_ff == '0))
      else $error("none result with non-zero distance");

   // Scan index never passes the searched count
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= limit_ff))
      else $error("scan index beyond count");

endmodule

// ===== tb/keyword_nearest_manhattan_distance_tb.sv =====
// ----------------------------------------------------------------------------
// keyword_nearest_manhattan_distance_tb
// Self-checking bench for the keyword nearest Manhattan distance block.
//
// Load and query beats go in over the req stream. A scoreboard keeps its own
// copy of the point table and of point_count, works out the nearest distance
// for every accepted query and compares each rsp beat with the oldest one
// outstanding. A short directed run covers the coordinate extremes, a query
// answered by its own keyword, a query on a slot outside the searched range
// and the empty-search cases. All 64 slots are then filled, and random
// phases follow under several point_count settings, including zero and
// values past the table size. Both sides idle at random, the receiver holds
// off once for a long stretch, the sender pauses until all results are back
// once mid-phase and before each count write; no query reads unloaded slots.
// ----------------------------------------------------------------------------
module keyword_nearest_manhattan_distance_tb;

   // Expected content of one rsp beat
   typedef struct packed {
      logic                        none_found;
      logic [knmd_pkg::DIST_W-1:0] distance;
   } nearest_type;

   class nearest_scoreboard;
      knmd_pkg::point_type        points [knmd_pkg::MAX_POINTS];
      logic [knmd_pkg::CNT_W-1:0] point_count;
      nearest_type                nearest_q [$];
      int                         errors;

      function new();
         point_count = 1;
         errors      = 0;
      endfunction

      function void set_count(input logic [knmd_pkg::CNT_W-1:0] value);
         point_count = value;
      endfunction

      function int pending();
         return nearest_q.size();
      endfunction

      function logic [knmd_pkg::DIST_W-1:0] gap(input logic [knmd_pkg::COORD_W-1:0] a,
                                                input logic [knmd_pkg::COORD_W-1:0] b);
         return (a >= b) ? knmd_pkg::DIST_W'(a - b) : knmd_pkg::DIST_W'(b - a);
      endfunction

      // Update the table on a load; on a query, queue the nearest distance
      function void note_request(input logic cmd, input logic [63:0] beat);
         logic [knmd_pkg::ADDR_W-1:0]   slot;
         logic [knmd_pkg::KW_IDX_W-1:0] kw;
         knmd_pkg::point_type           probe;
         logic [knmd_pkg::DIST_W-1:0]   best;
         logic [knmd_pkg::DIST_W-1:0]   d;
         logic                          found;
         int                            span;
         nearest_type                   want;
         slot = beat[5:0];
         kw   = beat[57:54];
         if (cmd == knmd_pkg::CMD_LOAD) begin
            points[slot] = '{kw_mask: beat[53:38], y: beat[37:22], x: beat[21:6]};
            return;
         end
         probe = points[slot];
         found = probe.kw_mask[kw];
         best  = '0;
         // Scan the searched slots only when the point lacks the keyword
         if (!found) begin
            span = (point_count > knmd_pkg::MAX_POINTS) ? knmd_pkg::MAX_POINTS
                                                         : int'(point_count);
            for (int i = 0; i < span; i++) begin
               if (points[i].kw_mask[kw]) begin
                  d = gap(probe.x, points[i].x) + gap(probe.y, points[i].y);
                  if (!found || d < best) begin
                     best  = d;
                     found = 1'b1;
                  end
               end
            end
         end
         want.none_found = !found;
         want.distance   = found ? best : '0;
         nearest_q.insert(nearest_q.size(), want);
      endfunction

      // Compare one rsp beat with the oldest outstanding query
      function void check_response(input logic [knmd_pkg::DIST_W-1:0] distance,
                                   input logic none_found);
         nearest_type want;
         if (nearest_q.size() == 0) begin
            $error("rsp beat with no query outstanding: distance %0d none_found %0b",
                   distance, none_found);
            errors++;
            return;
         end
         want = nearest_q.pop_front();
         if (distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, distance);
            errors++;
         end
         if (none_found !== want.none_found) begin
            $error("none_found: expected %0b, actual %0b", want.none_found, none_found);
            errors++;
         end
      endfunction

      function void close();
         if (nearest_q.size() != 0) begin
            $error("%0d query results never arrived", nearest_q.size());
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en;
   logic [6:0]  csr_wr_data;

   nearest_scoreboard sb = new();
   int  idle_pct = 6;
   bit  hold_request = 1'b0;
   int  hold_left;
   int  phase_count [8] = '{64, 127, 1, 0, 65, 2, 40, 64};

   keyword_nearest_manhattan_distance u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Coordinates: mostly uniform, with extremes and a tight cluster
   function automatic logic [15:0] rand_coord();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3:    return 16'h8000 + 16'($urandom_range(63));
         default: return 16'($urandom);
      endcase
   endfunction

   // Keyword masks: mostly sparse so that searches both hit and miss
   function automatic logic [15:0] rand_mask();
      case ($urandom_range(9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h0001 << $urandom_range(15);
         3:       return 16'($urandom);
         default: return 16'($urandom & $urandom & $urandom);
      endcase
   endfunction

   // Offer one beat, hold it until taken, then idle now and then
   task automatic send_beat(input logic cmd, input logic [5:0] slot,
                            input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] mask, input logic [3:0] kw);
      logic [63:0] beat;
      beat = {6'b0, kw, mask, y, x, slot};
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, beat);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic random_beat(input int query_pct);
      if ($urandom_range(99) < query_pct)
         send_beat(knmd_pkg::CMD_QUERY, 6'($urandom_range(63)), 16'($urandom),
                   16'($urandom), 16'($urandom), 4'($urandom_range(15)));
      else
         send_beat(knmd_pkg::CMD_LOAD, 6'($urandom_range(63)), rand_coord(),
                   rand_coord(), rand_mask(), 4'($urandom_range(15)));
   endtask

   // Drop valid and wait until every query has answered
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Write point_count once the block has gone quiet
   task automatic write_count(input logic [6:0] value);
      drain_results();
      repeat (80) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_count(value);
   endtask

   // Receiver: check each taken beat, stall at random or on request
   initial begin
      rsp_tready = 1'b0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata[knmd_pkg::DIST_W-1:0], rsp_tuser);
         if (hold_request) begin
            hold_left    = 400;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   initial begin
      #3000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int guard;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      guard       = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: corners of the coordinate space over four searched slots
      write_count(7'd4);
      send_beat(knmd_pkg::CMD_LOAD,  6'd0,  16'h0000, 16'h0000, 16'hFFFF, 4'd0);
      send_beat(knmd_pkg::CMD_LOAD,  6'd1,  16'hFFFF, 16'hFFFF, 16'h8000, 4'd15);
      send_beat(knmd_pkg::CMD_LOAD,  6'd2,  16'hFFFF, 16'h0000, 16'h0001, 4'd7);
      send_beat(knmd_pkg::CMD_LOAD,  6'd3,  16'h0000, 16'hFFFF, 16'h0000, 4'd3);
      send_beat(knmd_pkg::CMD_LOAD,  6'd63, 16'h1234, 16'hABCD, 16'h0002, 4'd9);
      // Opposite corner gives the largest distance
      send_beat(knmd_pkg::CMD_QUERY, 6'd1,  16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd3);
      // Queried point holds the keyword itself, then three queries found elsewhere
      send_beat(knmd_pkg::CMD_QUERY, 6'd0,  16'h0000, 16'h0000, 16'h0000, 4'd9);
      send_beat(knmd_pkg::CMD_QUERY, 6'd3,  16'h5A5A, 16'hA5A5, 16'h5A5A, 4'd0);
      send_beat(knmd_pkg::CMD_QUERY, 6'd3,  16'h0000, 16'h0000, 16'h0000, 4'd15);
      send_beat(knmd_pkg::CMD_QUERY, 6'd2,  16'h0000, 16'h0000, 16'h0000, 4'd14);
      // Queried slot outside the searched range
      send_beat(knmd_pkg::CMD_QUERY, 6'd63, 16'h0000, 16'h0000, 16'h0000, 4'd1);
      send_beat(knmd_pkg::CMD_QUERY, 6'd63, 16'h0000, 16'h0000, 16'h0000, 4'd15);

      // Nothing searched: only the point's own keyword can answer
      write_count(7'd0);
      send_beat(knmd_pkg::CMD_QUERY, 6'd3,  16'h0000, 16'h0000, 16'h0000, 4'd0);
      send_beat(knmd_pkg::CMD_QUERY, 6'd0,  16'h0000, 16'h0000, 16'h0000, 4'd5);

      // One searched slot, then an emptied slot leaves nothing to find
      write_count(7'd1);
      send_beat(knmd_pkg::CMD_QUERY, 6'd3,  16'h0000, 16'h0000, 16'h0000, 4'd4);
      send_beat(knmd_pkg::CMD_QUERY, 6'd1,  16'h0000, 16'h0000, 16'h0000, 4'd15);
      send_beat(knmd_pkg::CMD_LOAD,  6'd0,  16'h0000, 16'h0000, 16'h0000, 4'd0);
      send_beat(knmd_pkg::CMD_QUERY, 6'd3,  16'h0000, 16'h0000, 16'h0000, 4'd2);

      // Fill the whole table before any wider search
      for (int s = 0; s < knmd_pkg::MAX_POINTS; s++)
         send_beat(knmd_pkg::CMD_LOAD, 6'(s), rand_coord(), rand_coord(), rand_mask(),
                   4'($urandom_range(15)));

      // Random phases under several point_count settings
      for (int p = 0; p < 8; p++) begin
         write_count(p == 7 ? 7'($urandom_range(127)) : 7'(phase_count[p]));
         idle_pct = (p == 4) ? 0 : 6;
         for (int n = 0; n < 150; n++) begin
            if (p == 1 && n == 5)
               hold_request = 1'b1;
            if (p == 2 && n == 60)
               drain_results();
            random_beat(p == 1 ? 90 : 65);
         end
      end

      // Let the last results arrive, then allow for stragglers
      req_tvalid <= 1'b0;
      while (sb.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (100) @(posedge clock);
      sb.close();
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/knmd_pkg.sv
rtl/knmd_point_mem.sv
rtl/knmd_dist_unit.sv
rtl/keyword_nearest_manhattan_distance.sv
tb/keyword_nearest_manhattan_distance_tb.sv
